// ===== rtl/ecc_pkg.sv =====
// Shared types, constants and tables of the epoch-2000 calendar converter.
package ecc_pkg;

	typedef enum logic {
		ACT_SPLIT   = 1'b0,
		ACT_COMPOSE = 1'b1
	} ecc_action_t;

	typedef struct packed {
		ecc_action_t action;
		logic [31:0] seconds_in;
		logic [7:0]  year_in;
		logic [3:0]  month_in;
		logic [4:0]  mday_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} ecc_req_t;

	typedef struct packed {
		logic [31:0] total_seconds;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour_of_day;
		logic [2:0]  weekday;
		logic [7:0]  year_offset;
		logic [8:0]  day_of_year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
	} ecc_rsp_t;

	localparam logic [31:0] SECS_PER_DAY = 32'd86400;
	localparam logic [15:0] DAYS_CENTURY = 16'd36525;
	localparam logic [15:0] DAYS_QUAD    = 16'd1461;
	localparam logic [3:0]  MON_MAR      = 4'd2;

	// floor(2^35 / 675): seconds >> 7 times this, >> 35, gives day count or one less
	localparam logic [25:0] DAY_RECIP    = 26'd50903316;

	// days before the first of a month, non-leap; months past 11 repeat the
	// March-based 153-day pattern
	function automatic logic [8:0] month_base(input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			4'd12:   d = 9'd212;
			4'd13:   d = 9'd243;
			4'd14:   d = 9'd273;
			default: d = 9'd304;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/ecc_compose.sv =====
// Four-stage pipeline that builds the 32-bit seconds count of a transaction.
module ecc_compose import ecc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  ecc_req_t    req,
	output logic        sec_valid,
	input  logic        sec_stall,
	output logic [31:0] secs
);

	localparam int unsigned NS = 4;

	logic [NS:1] vld_q;
	logic [NS:1] en;

	logic [7:0]  yoff_m1;
	logic [1:0]  cent;
	logic [6:0]  leaps;
	logic        lp;
	logic [16:0] yday;
	logic [10:0] dmon;
	logic [16:0] tod;
	logic [31:0] days_x;

	ecc_action_t act_s1, act_s2, act_s3;
	logic [31:0] sin_s1, sin_s2, sin_s3;
	logic [16:0] yday_s1;
	logic [10:0] dmon_s1;
	logic [16:0] tod_s1, tod_s2, tod_s3;
	logic [17:0] days_s2;
	logic [31:0] prod_s3;
	logic [31:0] secs_s4;

	always_comb begin
		en[NS] = !vld_q[NS] || !sec_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	assign req_stall = !en[1];
	assign sec_valid = vld_q[NS];
	assign secs      = secs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= req_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// leap days before Jan 1, Gregorian within years 2000..2255
	always_comb begin
		yoff_m1 = req.year_in - 8'd1;
		cent    = (yoff_m1 >= 8'd200) ? 2'd2 : ((yoff_m1 >= 8'd100) ? 2'd1 : 2'd0);
		leaps   = (req.year_in == 8'd0) ? 7'd0 : 7'(yoff_m1[7:2]) - 7'(cent) + 7'd1;
		lp      = (req.year_in[1:0] == 2'd0) && (req.year_in != 8'd100)
			&& (req.year_in != 8'd200);
		yday    = 17'(req.year_in) * 17'd365 + 17'(leaps);
		dmon    = 11'(month_base(req.month_in))
			+ {10'd0, lp && (req.month_in >= MON_MAR)}
			+ 11'(req.mday_in) - 11'd1;
		tod     = 17'(req.hour_in) * 17'd3600 + 17'(req.minute_in) * 17'd60
			+ 17'(req.second_in);
		days_x  = {{14{days_s2[17]}}, days_s2};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			act_s1  <= req.action;
			sin_s1  <= req.seconds_in;
			yday_s1 <= yday;
			dmon_s1 <= dmon;
			tod_s1  <= tod;
		end
		if (en[2]) begin
			act_s2  <= act_s1;
			sin_s2  <= sin_s1;
			days_s2 <= {1'b0, yday_s1} + {{7{dmon_s1[10]}}, dmon_s1};
			tod_s2  <= tod_s1;
		end
		if (en[3]) begin
			act_s3  <= act_s2;
			sin_s3  <= sin_s2;
			prod_s3 <= days_x * SECS_PER_DAY;
			tod_s3  <= tod_s2;
		end
		if (en[4]) begin
			secs_s4 <= (act_s3 == ACT_COMPOSE) ? prod_s3 + 32'(tod_s3) : sin_s3;
		end
	end

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> !req_stall)
		else $error("input stalled with stage 1 empty");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_q[1])
		else $error("accepted transaction not in stage 1");

	a_days_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> $signed(days_s2) >= -18'sd1)
		else $error("composed day count below minus one");

endmodule

// ===== rtl/ecc_breakdown.sv =====
// Ten-stage pipeline that splits a seconds count into calendar fields.
module ecc_breakdown import ecc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sec_valid,
	output logic        sec_stall,
	input  logic [31:0] secs,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output ecc_rsp_t    rsp
);

	localparam int unsigned NS = 10;

	logic [NS:1] vld_q;
	logic [NS:1] en;

	// combinational per stage
	logic [50:0] qprod;
	logic [31:0] rfull;
	logic        ovf;
	logic        cen;
	logic [16:0] wx;
	logic [30:0] wprod;
	logic [22:0] hprod;
	logic [21:0] qprod4;
	logic [16:0] wr;
	logic [16:0] hr;
	logic        hc;
	logic [15:0] d2raw;
	logic        cq;
	logic [17:0] mprod;
	logic        leap;
	logic [7:0]  ybase;
	logic [10:0] dd;
	logic        big;
	logic [11:0] mr;
	logic        cm;
	logic [2:0]  yadd;
	logic [10:0] d3;
	logic [8:0]  nfeb;
	logic [8:0]  rm;
	logic [1:0]  ma;
	logic [1:0]  mb;
	logic [7:0]  r2;
	logic        c3;
	logic [3:0]  mon;
	logic [7:0]  md;

	logic [31:0] secs_s1, secs_s2, secs_s3, secs_s4, secs_s5;
	logic [31:0] secs_s6, secs_s7, secs_s8, secs_s9;
	logic [15:0] qe_s1, qe_s2;
	logic [17:0] r_s2;
	logic [15:0] days_s3;
	logic [16:0] frac_s3, frac_s4;
	logic        cen_s4, cen_s5, cen_s6;
	logic [15:0] d1_s4, d1_s5;
	logic [16:0] wx_s4;
	logic [12:0] we_s4;
	logic [4:0]  he_s4;
	logic [4:0]  q4e_s5, q4_s6;
	logic [2:0]  wd_s5, wd_s6, wd_s7, wd_s8, wd_s9;
	logic [4:0]  hour_s5, hour_s6, hour_s7, hour_s8, hour_s9;
	logic [11:0] remh_s5, remh_s6;
	logic [10:0] d2_s6;
	logic [5:0]  me_s6;
	logic [7:0]  years_s7, years_s8, years_s9;
	logic [10:0] dd_s7;
	logic        big_s7;
	logic        leap_s7, leap_s8;
	logic [5:0]  minute_s7, minute_s8, minute_s9;
	logic [5:0]  second_s7, second_s8, second_s9;
	logic [8:0]  doy_s8, doy_s9;
	logic        early_s9;
	logic        em_s9;
	logic [4:0]  emday_s9;
	logic [1:0]  ma_s9;
	logic [7:0]  r1_s9;
	ecc_rsp_t    rsp_s10;

	always_comb begin
		en[NS] = !vld_q[NS] || !rsp_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	assign sec_stall = !en[1];
	assign rsp_valid = vld_q[NS];
	assign rsp       = rsp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= sec_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	always_comb begin
		// day count estimate, fixed up by remainder compare
		qprod  = 51'(secs[31:7]) * 51'(DAY_RECIP);
		rfull  = secs_s1 - 32'(qe_s1) * SECS_PER_DAY;
		ovf    = r_s2 >= 18'(SECS_PER_DAY);

		// century split; weekday and hour estimates
		cen    = days_s3 >= DAYS_CENTURY;
		wx     = 17'(days_s3) + 17'd6;
		wprod  = 31'(wx) * 31'd9362;
		hprod  = 23'(frac_s3) * 23'd36;

		qprod4 = 22'(d1_s4) * 22'd44;
		wr     = wx_s4 - 17'(we_s4) * 17'd7;
		hr     = frac_s4 - 17'(he_s4) * 17'd3600;
		hc     = hr >= 17'd3600;

		d2raw  = d1_s5 - 16'(q4e_s5) * DAYS_QUAD;
		cq     = d2raw >= DAYS_QUAD;
		mprod  = 18'(remh_s5) * 18'd68;

		// year 2100 is the only non-leap year at the start of a quad
		leap   = !(cen_s6 && (q4_s6 == 5'd0));
		ybase  = (cen_s6 ? 8'd100 : 8'd0) + {1'b0, q4_s6, 2'b00};
		dd     = d2_s6 + {10'd0, cen_s6 && (q4_s6 != 5'd0)};
		big    = dd > (11'd364 + {10'd0, leap});
		mr     = remh_s6 - 12'(me_s6) * 12'd60;
		cm     = mr >= 12'd60;

		if (!big_s7) begin
			yadd = 3'd0;
		end else if (dd_s7 >= 11'd1460) begin
			yadd = 3'd4;
		end else if (dd_s7 >= 11'd1095) begin
			yadd = 3'd3;
		end else if (dd_s7 >= 11'd730) begin
			yadd = 3'd2;
		end else begin
			yadd = 3'd1;
		end
		d3     = dd_s7 - 11'(yadd) * 11'd365;

		nfeb   = 9'd59 + {8'd0, leap_s8};
		rm     = doy_s8 - nfeb;
		ma     = (rm >= 9'd306) ? 2'd2 : ((rm >= 9'd153) ? 2'd1 : 2'd0);

		mb     = (r1_s9 >= 8'd122) ? 2'd2 : ((r1_s9 >= 8'd61) ? 2'd1 : 2'd0);
		r2     = r1_s9 - 8'(mb) * 8'd61;
		c3     = r2 >= 8'd31;
		md     = c3 ? r2 - 8'd31 : r2;
		mon    = MON_MAR + 4'(ma_s9) * 4'd5 + 4'(mb) * 4'd2 + 4'(c3);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			secs_s1 <= secs;
			qe_s1   <= qprod[50:35];
		end
		if (en[2]) begin
			secs_s2 <= secs_s1;
			qe_s2   <= qe_s1;
			r_s2    <= rfull[17:0];
		end
		if (en[3]) begin
			secs_s3 <= secs_s2;
			days_s3 <= qe_s2 + 16'(ovf);
			frac_s3 <= 17'(ovf ? r_s2 - 18'(SECS_PER_DAY) : r_s2);
		end
		if (en[4]) begin
			secs_s4 <= secs_s3;
			cen_s4  <= cen;
			d1_s4   <= days_s3 - (cen ? DAYS_CENTURY : 16'd0);
			wx_s4   <= wx;
			we_s4   <= wprod[28:16];
			frac_s4 <= frac_s3;
			he_s4   <= hprod[21:17];
		end
		if (en[5]) begin
			secs_s5 <= secs_s4;
			cen_s5  <= cen_s4;
			d1_s5   <= d1_s4;
			q4e_s5  <= qprod4[20:16];
			wd_s5   <= 3'(wr >= 17'd7 ? wr - 17'd7 : wr);
			hour_s5 <= he_s4 + 5'(hc);
			remh_s5 <= 12'(hc ? hr - 17'd3600 : hr);
		end
		if (en[6]) begin
			secs_s6 <= secs_s5;
			cen_s6  <= cen_s5;
			q4_s6   <= q4e_s5 + 5'(cq);
			d2_s6   <= 11'(cq ? d2raw - DAYS_QUAD : d2raw);
			wd_s6   <= wd_s5;
			hour_s6 <= hour_s5;
			me_s6   <= mprod[17:12];
			remh_s6 <= remh_s5;
		end
		if (en[7]) begin
			secs_s7   <= secs_s6;
			years_s7  <= ybase;
			dd_s7     <= big ? dd - {10'd0, leap} : dd;
			big_s7    <= big;
			leap_s7   <= leap && !big;
			wd_s7     <= wd_s6;
			hour_s7   <= hour_s6;
			minute_s7 <= me_s6 + 6'(cm);
			second_s7 <= 6'(cm ? mr - 12'd60 : mr);
		end
		if (en[8]) begin
			secs_s8   <= secs_s7;
			years_s8  <= years_s7 + 8'(yadd);
			doy_s8    <= d3[8:0];
			leap_s8   <= leap_s7;
			wd_s8     <= wd_s7;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
		end
		if (en[9]) begin
			secs_s9   <= secs_s8;
			years_s9  <= years_s8;
			doy_s9    <= doy_s8;
			early_s9  <= doy_s8 < nfeb;
			em_s9     <= doy_s8 >= 9'd31;
			emday_s9  <= 5'(doy_s8 >= 9'd31 ? doy_s8 - 9'd31 : doy_s8);
			ma_s9     <= ma;
			r1_s9     <= 8'(rm - 9'(ma) * 9'd153);
			wd_s9     <= wd_s8;
			hour_s9   <= hour_s8;
			minute_s9 <= minute_s8;
			second_s9 <= second_s8;
		end
		if (en[10]) begin
			rsp_s10.total_seconds <= secs_s9;
			rsp_s10.second        <= second_s9;
			rsp_s10.minute        <= minute_s9;
			rsp_s10.hour_of_day   <= hour_s9;
			rsp_s10.weekday       <= wd_s9;
			rsp_s10.year_offset   <= years_s9;
			rsp_s10.day_of_year   <= doy_s9;
			rsp_s10.month         <= early_s9 ? {3'd0, em_s9} : mon;
			rsp_s10.day_of_month  <= early_s9 ? emday_s9 + 5'd1 : 5'(md) + 5'd1;
		end
	end

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> frac_s3 < 17'(SECS_PER_DAY))
		else $error("second of day not reduced below one day");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.hour_of_day < 5'd24 && rsp.minute < 6'd60
			&& rsp.second < 6'd60 && rsp.weekday < 3'd7)
		else $error("time of day or weekday out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.month < 4'd12 && rsp.day_of_month != 5'd0
			&& rsp.day_of_year < 9'd366)
		else $error("date field out of range");

	a_common_year: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.year_offset[1:0] != 2'd0 || rsp.year_offset == 8'd100)
			|-> rsp.day_of_year < 9'd365)
		else $error("day 365 in a common year");

endmodule

// ===== rtl/epoch2000_calendar_converter.sv =====
// Top level of the epoch-2000 calendar converter: compose pipeline then breakdown pipeline.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  request | req_valid | req_stall | req (ecc_req_t): action, seconds, fields
//  result  | rsp_valid | rsp_stall | rsp (ecc_rsp_t): seconds and breakdown
//
//  One transaction per cycle unless a stall holds the pipeline; each result passes
//  through the 4 compose stages, then the 10 breakdown stages.
//  Reset clears only the stage valid bits.
//  A held result stalls only the stages behind it; empty stages keep filling,
//  so req_stall rises only once every stage holds a transaction.
module epoch2000_calendar_converter import ecc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ecc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ecc_rsp_t rsp
);

	logic        sec_valid;
	logic        sec_stall;
	logic [31:0] secs;

	ecc_compose u_compose (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.sec_valid (sec_valid),
		.sec_stall (sec_stall),
		.secs      (secs)
	);

	ecc_breakdown u_breakdown (
		.clk       (clk),
		.arst_n    (arst_n),
		.sec_valid (sec_valid),
		.sec_stall (sec_stall),
		.secs      (secs),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the epoch-2000 calendar converter: random and directed requests.
module testbench import ecc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 530;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ecc_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ecc_rsp_t rsp;

	ecc_req_t pending_requests[$];
	ecc_rsp_t expected_breakdowns[$];
	ecc_rsp_t want_rsp;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	epoch2000_calendar_converter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] compose_seconds(ecc_req_t r);
		logic [31:0] yoff, mon, leaps, total, d, k, yr, m, leap;
		yoff = 32'(r.year_in);
		mon = 32'(r.month_in);
		leaps = 0;
		if (yoff != 0) begin
			m = yoff - 1;
			leaps = m / 4 - m / 100 + 1;
		end
		total = 365 * yoff + leaps;
		d = {27'd0, r.mday_in} - 32'd1;
		if (mon < 2) begin
			if (mon != 0)
				d = d + 31;
		end else begin
			yr = yoff + 2000;
			leap = ((yr % 4 == 0) && ((yr % 100 != 0) || ((yr / 100) % 4 == 0))) ? 1 : 0;
			k = mon - 2;
			d = d + 59 + leap;
			if (k > 4)
				d = d + 153;
			k = k % 5;
			d = d + (k / 2) * 61;
			if (k[0])
				d = d + 31;
		end
		total = total + d;
		total = total * 32'd86400;
		total = total + {27'd0, r.hour_in} * 32'd3600 + {26'd0, r.minute_in} * 32'd60
			+ {26'd0, r.second_in};
		return total;
	endfunction

	function automatic ecc_rsp_t break_down_seconds(logic [31:0] secs);
		ecc_rsp_t o;
		logic [31:0] days, frac, years, leap, n, mon, mday, r;
		days = secs / 32'd86400;
		frac = secs % 32'd86400;
		o.total_seconds = secs;
		o.second = 6'(frac % 60);
		o.minute = 6'((frac / 60) % 60);
		o.hour_of_day = 5'(frac / 3600);
		o.weekday = 3'((days + 6) % 7);
		years = 100 * (days / 36525);
		days = days % 36525;
		years = years + 4 * (days / 1461);
		days = days % 1461;
		if (years > 100)
			days = days + 1;
		leap = (years == 100) ? 0 : 1;
		n = 364 + leap;
		if (days > n) begin
			days = days - leap;
			leap = 0;
			years = years + days / 365;
			days = days % 365;
		end
		o.year_offset = years[7:0];
		o.day_of_year = days[8:0];
		n = 59 + leap;
		if (days < n) begin
			mon = days / 31;
			mday = days % 31;
		end else begin
			r = days - n;
			mon = 2 + 5 * (r / 153);
			r = r % 153;
			mon = mon + 2 * (r / 61);
			r = r % 61;
			mon = mon + r / 31;
			mday = r % 31;
		end
		o.month = mon[3:0];
		o.day_of_month = 5'(mday + 1);
		return o;
	endfunction

	function automatic ecc_rsp_t expected_breakdown(ecc_req_t r);
		if (r.action == ACT_COMPOSE)
			return break_down_seconds(compose_seconds(r));
		return break_down_seconds(r.seconds_in);
	endfunction

	task automatic add_request(ecc_action_t act, logic [31:0] secs, logic [7:0] y,
		logic [3:0] mo, logic [4:0] md, logic [4:0] h, logic [5:0] mi, logic [5:0] s);
		ecc_req_t r;
		r.action = act;
		r.seconds_in = (act == ACT_SPLIT) ? secs : $urandom;
		r.year_in = y;
		r.month_in = mo;
		r.mday_in = md;
		r.hour_in = h;
		r.minute_in = mi;
		r.second_in = s;
		pending_requests.push_back(r);
	endtask

	function automatic ecc_req_t random_request();
		ecc_req_t r;
		int unsigned sel;
		sel = $urandom_range(99);
		r.action = ACT_COMPOSE;
		r.seconds_in = $urandom;
		r.year_in = 8'($urandom);
		r.month_in = 4'($urandom);
		r.mday_in = 5'($urandom);
		r.hour_in = 5'($urandom);
		r.minute_in = 6'($urandom);
		r.second_in = 6'($urandom);
		if (sel < 45) begin
			r.action = ACT_SPLIT;
			if (sel < 15)
				r.seconds_in = $urandom_range(49710) * 32'd86400 + $urandom_range(2) - 1;
		end else if (sel < 90) begin
			r.year_in = 8'($urandom_range(136));
			r.month_in = 4'($urandom_range(11));
			r.mday_in = 5'($urandom_range(31, 1));
			r.hour_in = 5'($urandom_range(23));
			r.minute_in = 6'($urandom_range(59));
			r.second_in = 6'($urandom_range(59));
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic compare_breakdown(ecc_rsp_t got, ecc_rsp_t want);
		if (got.total_seconds !== want.total_seconds)
			report_mismatch("total_seconds", got.total_seconds, want.total_seconds);
		if (got.second !== want.second)
			report_mismatch("second", 32'(got.second), 32'(want.second));
		if (got.minute !== want.minute)
			report_mismatch("minute", 32'(got.minute), 32'(want.minute));
		if (got.hour_of_day !== want.hour_of_day)
			report_mismatch("hour_of_day", 32'(got.hour_of_day), 32'(want.hour_of_day));
		if (got.weekday !== want.weekday)
			report_mismatch("weekday", 32'(got.weekday), 32'(want.weekday));
		if (got.year_offset !== want.year_offset)
			report_mismatch("year_offset", 32'(got.year_offset), 32'(want.year_offset));
		if (got.day_of_year !== want.day_of_year)
			report_mismatch("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year));
		if (got.month !== want.month)
			report_mismatch("month", 32'(got.month), 32'(want.month));
		if (got.day_of_month !== want.day_of_month)
			report_mismatch("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month));
	endtask

	// driver: next transaction goes out once the current one is taken
	always @(posedge clk) begin
		if (arst_n && (!req_valid || !req_stall)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				expected_breakdowns.push_back(expected_breakdown(pending_requests[0]));
				req <= pending_requests.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_breakdowns.size() == 0) begin
					report_mismatch("unexpected result, total_seconds", rsp.total_seconds,
						32'd0);
				end else begin
					want_rsp = expected_breakdowns.pop_front();
					compare_breakdown(rsp, want_rsp);
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL epoch2000_calendar_converter");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 47 : 0;
			recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 38 : 0;
			if (phase == 0) begin
				add_request(ACT_SPLIT, 32'd0, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
				add_request(ACT_SPLIT, 32'hFFFF_FFFF, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd86399, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd5097600, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd5184000, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd31536000, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd3155760000, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_SPLIT, 32'd3160857600, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd136, 4'd1, 5'd7, 5'd6, 6'd28, 6'd15);
				add_request(ACT_COMPOSE, 32'd0, 8'd136, 4'd1, 5'd7, 5'd6, 6'd28, 6'd16);
				add_request(ACT_COMPOSE, 32'd0, 8'd100, 4'd1, 5'd29, 5'd12, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd100, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd104, 4'd1, 5'd29, 5'd23, 6'd59, 6'd59);
				add_request(ACT_COMPOSE, 32'd0, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd4, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0);
				add_request(ACT_COMPOSE, 32'd0, 8'd24, 4'd13, 5'd15, 5'd1, 6'd2, 6'd3);
				add_request(ACT_COMPOSE, 32'd0, 8'd77, 4'd14, 5'd30, 5'd4, 6'd5, 6'd6);
				add_request(ACT_COMPOSE, 32'd0, 8'd200, 4'd15, 5'd31, 5'd7, 6'd8, 6'd9);
				add_request(ACT_COMPOSE, 32'd0, 8'd50, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59);
				add_request(ACT_COMPOSE, 32'd0, 8'd136, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59);
				add_request(ACT_COMPOSE, 32'd0, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				pending_requests.push_back(random_request());
			// hold off until every transaction of the phase has come back
			while (pending_requests.size() != 0 || expected_breakdowns.size() != 0)
				@(posedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS epoch2000_calendar_converter");
		else
			$display("FAIL epoch2000_calendar_converter");
		$finish;
	end

endmodule
